FILE: design/dma_rx_channel_with_shadow_queue_assert.svh
// ----------------------------------------------------------------------------
// dma_rx_channel_with_shadow_queue_assert.svh
// Assertion macros shared by the receive DMA channel. Each macro expects
// clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef DMA_RX_CHANNEL_WITH_SHADOW_QUEUE_ASSERT_SVH
`define DMA_RX_CHANNEL_WITH_SHADOW_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drx assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DRX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drx assertion failed");

`endif

FILE: design/drx_pkg.sv
// ----------------------------------------------------------------------------
// drx_pkg
// Types, codes and constants shared by the receive DMA channel modules.
// ----------------------------------------------------------------------------
`default_nettype none

package drx_pkg;

    localparam int DRX_SIZE_BITS   = 20;
    localparam int DRX_QUEUE_DEPTH = 2;

    // Input item kinds.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_PUSH  = 2'd2;

    // Register byte offsets.
    localparam logic [3:0] OFF_ADDR = 4'd0;
    localparam logic [3:0] OFF_SIZE = 4'd4;
    localparam logic [3:0] OFF_CFG  = 4'd8;

    // Config word bit positions.
    localparam int CFG_CONT  = 0;
    localparam int CFG_WIDTH = 1;
    localparam int CFG_EN    = 4;
    localparam int CFG_CLR   = 5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WR_ADDR,
        OP_WR_SIZE,
        OP_WR_CFG,
        OP_RD_ADDR,
        OP_RD_SIZE,
        OP_RD_CFG,
        OP_BAD,
        OP_PUSH
    } drx_op_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        drx_op_t     op;
        logic [31:0] data;
        logic [2:0]  nbytes;
    } drx_cmd_t;

    // One result item.
    typedef struct packed {
        logic [31:0] read_data;
        logic        access_error;
        logic        mem_write_valid;
        logic [31:0] mem_write_addr;
        logic [31:0] mem_write_word;
        logic [2:0]  mem_write_bytes;
        logic        transfer_done;
    } drx_res_t;

    // Back end status, observed by the top level.
    typedef struct packed {
        logic       exec_fire;
        logic [1:0] desc_count;
        logic [1:0] outq_count;
    } drx_stat_t;

endpackage

`default_nettype wire

FILE: design/drx_front.sv
// ----------------------------------------------------------------------------
// drx_front
// Accepts input items, classifies them into commands and holds them in a
// two-entry command queue in front of the execution stage.
// ----------------------------------------------------------------------------
`default_nettype none

module drx_front
    import drx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  reg_offset,
    input  wire logic [31:0] write_data,
    input  wire logic [2:0]  push_bytes,
    input  wire logic [31:0] push_value,
    output logic             cmd_valid,
    output drx_cmd_t         cmd,
    input  wire logic        cmd_pop
);

    drx_cmd_t   entry_reg [2];
    drx_cmd_t   dec;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    // Classify the incoming item.
    always_comb
    begin
        dec.op     = OP_NOP;
        dec.data   = write_data;
        dec.nbytes = push_bytes;
        unique case (kind)
            KIND_WRITE:
            begin
                unique case (reg_offset)
                    OFF_ADDR: dec.op = OP_WR_ADDR;
                    OFF_SIZE: dec.op = OP_WR_SIZE;
                    OFF_CFG:  dec.op = OP_WR_CFG;
                    default:  dec.op = OP_BAD;
                endcase
            end
            KIND_READ:
            begin
                unique case (reg_offset)
                    OFF_ADDR: dec.op = OP_RD_ADDR;
                    OFF_SIZE: dec.op = OP_RD_SIZE;
                    OFF_CFG:  dec.op = OP_RD_CFG;
                    default:  dec.op = OP_BAD;
                endcase
            end
            KIND_PUSH:
            begin
                dec.data = push_value;
                // Pushes of zero or more than four bytes are dropped here.
                if (push_bytes != 3'd0 && push_bytes <= 3'd4)
                    dec.op = OP_PUSH;
                else
                    dec.op = OP_NOP;
            end
            default: dec.op = OP_NOP;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= dec;
    end

endmodule

`default_nettype wire

FILE: design/drx_back.sv
// ----------------------------------------------------------------------------
// drx_back
// Executes classified commands against the register and descriptor state,
// packs pushed bytes into memory words and queues one result per command.
// ----------------------------------------------------------------------------
`default_nettype none

module drx_back
    import drx_pkg::*;
#(
    parameter int SIZE_BITS = DRX_SIZE_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    input  wire drx_cmd_t cmd,
    output logic          cmd_pop,
    output logic          empty,
    output drx_res_t      res,
    input  wire logic     pop,
    output drx_stat_t     stat
);

    localparam int REM_W = SIZE_BITS + 1;

    // Register and descriptor state.
    logic [31:0]          start_addr_reg, start_addr_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic                 cont_reg, cont_next;
    logic                 width_reg, width_next;
    logic [1:0]           desc_count_reg, desc_count_next;
    logic                 head_reg, head_next;
    logic [31:0]          pack_word_reg, pack_word_next;
    logic [2:0]           pack_idx_reg, pack_idx_next;

    logic [31:0]             desc_addr_reg [2];
    logic signed [REM_W-1:0] desc_rem_reg  [2];

    // Descriptor write port.
    logic                    desc_wr;
    logic                    desc_wr_slot;
    logic [31:0]             desc_wr_addr;
    logic signed [REM_W-1:0] desc_wr_rem;

    // Result queue.
    drx_res_t   outq_reg [2];
    logic       oq_wr_ptr_reg, oq_rd_ptr_reg;
    logic [1:0] oq_count_reg, oq_count_next;
    logic       exec_fire, do_pop;
    drx_res_t   r;

    // Push datapath.
    logic                    busy;
    logic                    queue_full;
    logic [31:0]             shifted;
    logic [2:0]              new_idx;
    logic [3:0]              idx_end;
    logic signed [REM_W-1:0] head_rem;
    logic signed [REM_W-1:0] rem_after;
    logic [31:0]             head_addr;

    assign exec_fire  = cmd_valid && (oq_count_reg != 2'd2);
    assign cmd_pop    = exec_fire;
    assign do_pop     = pop && !empty;
    assign empty      = (oq_count_reg == 2'd0);
    assign res        = outq_reg[oq_rd_ptr_reg];
    assign busy       = (desc_count_reg != 2'd0);
    assign queue_full = (desc_count_reg >= 2'(DRX_QUEUE_DEPTH));
    assign head_rem   = desc_rem_reg[head_reg];
    assign head_addr  = desc_addr_reg[head_reg];
    assign shifted    = cmd.data << {pack_idx_reg[1:0], 3'b000};
    assign new_idx    = pack_idx_reg + cmd.nbytes;
    assign idx_end    = {1'b0, new_idx};
    assign rem_after  = head_rem - REM_W'(4);

    always_comb
    begin
        start_addr_next = start_addr_reg;
        size_next       = size_reg;
        cont_next       = cont_reg;
        width_next      = width_reg;
        desc_count_next = desc_count_reg;
        head_next       = head_reg;
        pack_word_next  = pack_word_reg;
        pack_idx_next   = pack_idx_reg;
        desc_wr         = 1'b0;
        desc_wr_slot    = head_reg ^ desc_count_reg[0];
        desc_wr_addr    = start_addr_reg;
        desc_wr_rem     = $signed({1'b0, size_reg});
        r               = '0;

        unique case (cmd.op)
            OP_WR_ADDR: start_addr_next = cmd.data;
            OP_WR_SIZE: size_next = cmd.data[SIZE_BITS-1:0];
            OP_WR_CFG:
            begin
                cont_next  = cmd.data[CFG_CONT];
                width_next = cmd.data[CFG_WIDTH];
                if (cmd.data[CFG_CLR])
                    r.access_error = 1'b1;
                else if (cmd.data[CFG_EN] && !queue_full)
                begin
                    desc_wr         = 1'b1;
                    desc_count_next = desc_count_reg + 2'd1;
                end
            end
            OP_RD_ADDR: r.read_data = start_addr_reg;
            OP_RD_SIZE: r.read_data = 32'(size_reg);
            OP_RD_CFG:
            begin
                r.read_data[CFG_CONT]  = cont_reg;
                r.read_data[CFG_WIDTH] = width_reg;
                r.read_data[CFG_EN]    = busy;
                r.read_data[CFG_CLR]   = queue_full;
            end
            OP_BAD: r.access_error = 1'b1;
            OP_PUSH:
            begin
                if (busy && ({1'b0, pack_idx_reg} + {1'b0, cmd.nbytes}) <= 4'd4)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        if (4'(j) >= {1'b0, pack_idx_reg} && 4'(j) < idx_end)
                            pack_word_next[8*j +: 8] = shifted[8*j +: 8];
                    end
                    pack_idx_next = new_idx;
                    if (new_idx == 3'd4 || $signed({{(REM_W-3){1'b0}}, new_idx}) >= head_rem)
                    begin
                        pack_idx_next     = 3'd0;
                        r.mem_write_valid = 1'b1;
                        r.mem_write_addr  = {head_addr[31:2], 2'b00};
                        r.mem_write_word  = pack_word_next;
                        if (head_rem > REM_W'(4))
                            r.mem_write_bytes = 3'd4;
                        else if (head_rem < 0)
                            r.mem_write_bytes = 3'd0;
                        else
                            r.mem_write_bytes = head_rem[2:0];
                        desc_wr      = 1'b1;
                        desc_wr_slot = head_reg;
                        desc_wr_addr = head_addr + 32'd4;
                        desc_wr_rem  = rem_after;
                        if (rem_after <= 0)
                        begin
                            r.transfer_done = 1'b1;
                            head_next       = !head_reg;
                            desc_count_next = desc_count_reg - 2'd1;
                        end
                    end
                end
            end
            default: ;
        endcase

        oq_count_next = oq_count_reg + 2'(exec_fire) - 2'(do_pop);
    end

    assign stat.exec_fire  = exec_fire;
    assign stat.desc_count = desc_count_reg;
    assign stat.outq_count = oq_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_addr_reg <= '0;
            size_reg       <= '0;
            cont_reg       <= 1'b0;
            width_reg      <= 1'b0;
            desc_count_reg <= 2'd0;
            head_reg       <= 1'b0;
            pack_word_reg  <= '0;
            pack_idx_reg   <= 3'd0;
            oq_wr_ptr_reg  <= 1'b0;
            oq_rd_ptr_reg  <= 1'b0;
            oq_count_reg   <= 2'd0;
        end
        else
        begin
            if (exec_fire)
            begin
                start_addr_reg <= start_addr_next;
                size_reg       <= size_next;
                cont_reg       <= cont_next;
                width_reg      <= width_next;
                desc_count_reg <= desc_count_next;
                head_reg       <= head_next;
                pack_word_reg  <= pack_word_next;
                pack_idx_reg   <= pack_idx_next;
                oq_wr_ptr_reg  <= !oq_wr_ptr_reg;
            end
            if (do_pop)
                oq_rd_ptr_reg <= !oq_rd_ptr_reg;
            oq_count_reg <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire && desc_wr)
        begin
            desc_addr_reg[desc_wr_slot] <= desc_wr_addr;
            desc_rem_reg[desc_wr_slot]  <= desc_wr_rem;
        end
        if (exec_fire)
            outq_reg[oq_wr_ptr_reg] <= r;
    end

endmodule

`default_nettype wire

FILE: design/dma_rx_channel_with_shadow_queue.sv
// ----------------------------------------------------------------------------
// dma_rx_channel_with_shadow_queue
// Receive DMA channel: register access, descriptor queue and byte packing.
// ----------------------------------------------------------------------------
// Both sides look like a queue. An item (register write, register read or
// peripheral push of 1 to 4 bytes) is taken when push is high and full low.
// Every item produces exactly one result item, shown while empty is low and
// taken when pop is high. The result carries read data, an access error flag,
// an optional aligned memory word write and an end-of-transfer pulse.
// The front end classifies items into a two-entry command queue; the back
// end executes one command per cycle while the result queue has room and
// writes a two-entry result queue. An accepted item passes through the
// command queue and is registered into the result queue before it is
// visible. The sustained rate is one item per cycle while the receiver
// keeps popping; descriptor and packing state update for each command.
// If the receiver stalls, the result queue fills, the back end stops, then
// the command queue fills and full rises; nothing is lost or repeated.
// Reset clears both queues, the shadow registers, the descriptor count and
// the packing state; descriptor entries are loaded when queued.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_rx_channel_with_shadow_queue
    import drx_pkg::*;
#(
    parameter int SIZE_BITS = DRX_SIZE_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  reg_offset,
    input  wire logic [31:0] write_data,
    input  wire logic [2:0]  push_bytes,
    input  wire logic [31:0] push_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      read_data,
    output logic             access_error,
    output logic             mem_write_valid,
    output logic [31:0]      mem_write_addr,
    output logic [31:0]      mem_write_word,
    output logic [2:0]       mem_write_bytes,
    output logic             transfer_done
);

    logic      cmd_valid;
    logic      cmd_pop;
    drx_cmd_t  cmd;
    drx_res_t  res;
    drx_stat_t stat;

    drx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .push_bytes (push_bytes),
        .push_value (push_value),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    drx_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .res       (res),
        .pop       (pop),
        .stat      (stat)
    );

    assign read_data       = res.read_data;
    assign access_error    = res.access_error;
    assign mem_write_valid = res.mem_write_valid;
    assign mem_write_addr  = res.mem_write_addr;
    assign mem_write_word  = res.mem_write_word;
    assign mem_write_bytes = res.mem_write_bytes;
    assign transfer_done   = res.transfer_done;

`include "dma_rx_channel_with_shadow_queue_assert.svh"

    // The descriptor count never goes beyond the two-entry shadow queue.
    `DRX_ASSERT_NOW(a_desc_bound, 1'b1, stat.desc_count != 2'd3)
    // The back end only executes while the result queue has room.
    `DRX_ASSERT_NOW(a_exec_room, stat.exec_fire, stat.outq_count != 2'd2)
    // An accepted item is waiting for the back end on the next cycle.
    `DRX_ASSERT_NEXT(a_cmd_follows, push && !full, cmd_valid)
    // A memory write result never carries register read data or an error.
    `DRX_ASSERT_NOW(a_write_clean, !empty && mem_write_valid, !access_error && read_data == 32'd0)

endmodule

`default_nettype wire

FILE: tb/tb_dma_rx_channel_with_shadow_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dma_rx_channel_with_shadow_queue
// Self-checking bench for the receive DMA channel. A driver feeds register
// accesses and peripheral pushes from a queue of pending items, a predictor
// computes the result of each accepted item, and a monitor compares every
// popped result with the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------

module tb_dma_rx_channel_with_shadow_queue;
    import drx_pkg::*;

    // The kind code that the channel treats as a no-op.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Invalid register offsets used by the directed part.
    localparam logic [3:0] OFF_BAD_WR = 4'd15;
    localparam logic [3:0] OFF_BAD_RD = 4'd12;

    localparam int unsigned RANDOM_ITEMS = 850;
    // The limit is far above the slowest correct run, even with every item
    // waiting out the longest gap on both sides.
    localparam int unsigned CYCLE_LIMIT  = 500000;
    // Wait after the last expected result so that a stray one is caught.
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  reg_offset;
        logic [31:0] write_data;
        logic [2:0]  push_bytes;
        logic [31:0] push_value;
    } rx_item_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports. All inputs start at known values.
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  kind = '0;
    logic [3:0]  reg_offset = '0;
    logic [31:0] write_data = '0;
    logic [2:0]  push_bytes = '0;
    logic [31:0] push_value = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] read_data;
    logic        access_error;
    logic        mem_write_valid;
    logic [31:0] mem_write_addr;
    logic [31:0] mem_write_word;
    logic [2:0]  mem_write_bytes;
    logic        transfer_done;

    always #5 clk = ~clk;

    dma_rx_channel_with_shadow_queue DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .kind            (kind),
        .reg_offset      (reg_offset),
        .write_data      (write_data),
        .push_bytes      (push_bytes),
        .push_value      (push_value),
        .empty           (empty),
        .pop             (pop),
        .read_data       (read_data),
        .access_error    (access_error),
        .mem_write_valid (mem_write_valid),
        .mem_write_addr  (mem_write_addr),
        .mem_write_word  (mem_write_word),
        .mem_write_bytes (mem_write_bytes),
        .transfer_done   (transfer_done)
    );

    // ------------------------------------------------------------------
    // Bench bookkeeping.
    // ------------------------------------------------------------------
    rx_item_t    pending_items[$];
    drx_res_t    expected_results[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned item_total = 0;

    int unsigned send_gap = 0;
    int unsigned send_quiet = 0;
    int unsigned pop_stall = 0;
    int unsigned pop_quiet = 0;

    rx_item_t    taken_item;
    drx_res_t    taken_res;
    drx_res_t    oldest_res;

    // ------------------------------------------------------------------
    // Predictor state: shadow registers, the two-entry descriptor queue and
    // the byte packer. Reset values are given here; reset happens once.
    // ------------------------------------------------------------------
    logic [31:0]              sh_addr = '0;
    logic [DRX_SIZE_BITS-1:0] sh_size = '0;
    logic                     sh_cont = 1'b0;
    logic                     sh_width = 1'b0;
    logic [31:0]              dq_addr[DRX_QUEUE_DEPTH] = '{default: '0};
    longint                   dq_left[DRX_QUEUE_DEPTH] = '{default: 0};
    int unsigned              dq_count = 0;
    int unsigned              dq_head = 0;
    logic                     ch_active = 1'b0;
    logic [31:0]              pack_buf = '0;
    int unsigned              pack_fill = 0;

    // Computes the result of one accepted item and advances the channel
    // state exactly as the block should.
    task automatic predict_channel(input rx_item_t it, output drx_res_t r);
        int unsigned tail;
        int unsigned nb;
        longint      left;
        r = '0;
        nb = it.push_bytes;
        if (it.kind == KIND_WRITE || it.kind == KIND_READ) begin
            if (it.reg_offset == OFF_ADDR) begin
                if (it.kind == KIND_WRITE)
                    sh_addr = it.write_data;
                else
                    r.read_data = sh_addr;
            end
            else if (it.reg_offset == OFF_SIZE) begin
                if (it.kind == KIND_WRITE)
                    sh_size = it.write_data[DRX_SIZE_BITS-1:0];
                else
                    r.read_data = 32'(sh_size);
            end
            else if (it.reg_offset == OFF_CFG) begin
                if (it.kind == KIND_WRITE) begin
                    // Mode bits are taken even when a clear is requested.
                    sh_cont  = it.write_data[CFG_CONT];
                    sh_width = it.write_data[CFG_WIDTH];
                    if (it.write_data[CFG_CLR])
                        r.access_error = 1'b1;
                    else if (it.write_data[CFG_EN] && dq_count < DRX_QUEUE_DEPTH) begin
                        tail = (dq_head + dq_count) % DRX_QUEUE_DEPTH;
                        dq_addr[tail] = sh_addr;
                        dq_left[tail] = longint'(sh_size);
                        dq_count++;
                        ch_active = 1'b1;
                    end
                end
                else begin
                    r.read_data[CFG_CONT]  = sh_cont;
                    r.read_data[CFG_WIDTH] = sh_width;
                    r.read_data[CFG_EN]    = (dq_count != 0);
                    r.read_data[CFG_CLR]   = (dq_count >= DRX_QUEUE_DEPTH);
                end
            end
            else begin
                r.access_error = 1'b1;
            end
        end
        else if (it.kind == KIND_PUSH && ch_active && nb >= 1 && nb <= 4
                 && nb + pack_fill <= 4) begin
            // Bytes land little-endian above the ones already collected;
            // bytes above the new fill level keep whatever they held.
            for (int i = 0; i < nb; i++)
                pack_buf[8*(pack_fill+i) +: 8] = it.push_value[8*i +: 8];
            pack_fill += nb;
            left = dq_left[dq_head];
            if (pack_fill >= 4 || longint'(pack_fill) >= left) begin
                pack_fill = 0;
                r.mem_write_valid = 1'b1;
                r.mem_write_addr  = {dq_addr[dq_head][31:2], 2'b00};
                r.mem_write_word  = pack_buf;
                r.mem_write_bytes = (left > 4) ? 3'd4 : (left < 0 ? 3'd0 : 3'(left));
                dq_addr[dq_head] = dq_addr[dq_head] + 32'd4;
                left = left - 4;
                dq_left[dq_head] = left;
                if (left <= 0) begin
                    r.transfer_done = 1'b1;
                    dq_head = (dq_head + 1) % DRX_QUEUE_DEPTH;
                    if (dq_count > 0)
                        dq_count--;
                    ch_active = (dq_count != 0);
                end
            end
        end
    endtask

    // Idle length between handshakes: mostly none or short, now and then
    // long, with occasional stretches where no idling happens at all.
    function automatic int unsigned draw_idle(inout int unsigned quiet_left);
        int unsigned pick;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers. Fields that an item does not use carry random
    // values so that the block is seen to ignore them.
    // ------------------------------------------------------------------
    task automatic add_item(input logic [1:0] k, input logic [3:0] off,
                            input logic [31:0] wd, input logic [2:0] nb,
                            input logic [31:0] pv);
        rx_item_t it;
        it.kind       = k;
        it.reg_offset = off;
        it.write_data = wd;
        it.push_bytes = nb;
        it.push_value = pv;
        pending_items.push_back(it);
        item_total++;
    endtask

    task automatic reg_wr(input logic [3:0] off, input logic [31:0] wd);
        add_item(KIND_WRITE, off, wd, 3'($urandom), $urandom);
    endtask

    task automatic reg_rd(input logic [3:0] off);
        add_item(KIND_READ, off, $urandom, 3'($urandom), $urandom);
    endtask

    task automatic byte_push(input logic [2:0] nb, input logic [31:0] pv);
        add_item(KIND_PUSH, 4'($urandom), $urandom, nb, pv);
    endtask

    // ------------------------------------------------------------------
    // Driver. The head of the pending queue is presented until the block
    // takes it; the predictor runs on the item at the edge of acceptance.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end
        else begin
            if (push && !full) begin
                taken_item = pending_items.pop_front();
                predict_channel(taken_item, taken_res);
                expected_results.push_back(taken_res);
                send_gap = draw_idle(send_quiet);
            end
            if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end
            else if (pending_items.size() > 0) begin
                push       <= 1'b1;
                kind       <= pending_items[0].kind;
                reg_offset <= pending_items[0].reg_offset;
                write_data <= pending_items[0].write_data;
                push_bytes <= pending_items[0].push_bytes;
                push_value <= pending_items[0].push_value;
            end
            else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Every popped result is compared with the oldest prediction.
    // The result ports are sampled at the edge, before any update lands.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end
        else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with nothing expected, read_data %h",
                             $time, read_data);
                    mismatches++;
                end
                else begin
                    oldest_res = expected_results.pop_front();
                    check_field("read_data", oldest_res.read_data, read_data);
                    check_field("access_error", 32'(oldest_res.access_error),
                                32'(access_error));
                    check_field("mem_write_valid", 32'(oldest_res.mem_write_valid),
                                32'(mem_write_valid));
                    check_field("mem_write_addr", oldest_res.mem_write_addr,
                                mem_write_addr);
                    check_field("mem_write_word", oldest_res.mem_write_word,
                                mem_write_word);
                    check_field("mem_write_bytes", 32'(oldest_res.mem_write_bytes),
                                32'(mem_write_bytes));
                    check_field("transfer_done", 32'(oldest_res.transfer_done),
                                32'(transfer_done));
                end
                pop_stall = draw_idle(pop_quiet);
            end
            if (pop_stall > 0) begin
                pop_stall--;
                pop <= 1'b0;
            end
            else begin
                pop <= 1'b1;
            end
        end
    end

    // A run that stalls ends here as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int unsigned pick;
        int unsigned xfer_len;
        int unsigned extra_len;
        int unsigned sent;
        int unsigned fill;
        int unsigned nb;
        logic [1:0]  k;
        logic [3:0]  off;
        logic [31:0] wd;

        // Directed part. Reset values of the config word and the size.
        reg_rd(OFF_CFG);
        reg_rd(OFF_SIZE);
        // The size register keeps only its low bits.
        reg_wr(OFF_SIZE, 32'hFFFF_FFFF);
        reg_rd(OFF_SIZE);
        // Invalid offsets answer with an error and have no effect.
        reg_wr(OFF_BAD_WR, $urandom);
        reg_rd(OFF_BAD_RD);
        // The unused kind does nothing at all.
        add_item(KIND_UNUSED, OFF_CFG, 32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF);
        // A push with no active transfer is dropped.
        byte_push(3'd4, 32'hFFFF_FFFF);
        // A clear request takes the mode bits but ignores the enable.
        reg_wr(OFF_CFG, 32'h0000_0033);
        reg_rd(OFF_CFG);
        // A zero-size descriptor ends on its first push with a zero-byte write.
        reg_wr(OFF_SIZE, 32'd0);
        reg_wr(OFF_CFG, 32'h0000_0010);
        byte_push(3'd1, 32'h0000_00A5);
        // Two descriptors from an unaligned address near the top of memory;
        // the third enable finds the queue full and is ignored.
        reg_wr(OFF_ADDR, 32'hFFFF_FFFD);
        reg_wr(OFF_SIZE, 32'd5);
        reg_wr(OFF_CFG, 32'h0000_0010);
        reg_wr(OFF_CFG, 32'h0000_0011);
        reg_wr(OFF_CFG, 32'h0000_0012);
        reg_rd(OFF_CFG);
        // Pushes of zero and of more than four bytes are dropped, as is one
        // that would overflow the word. The address wraps past the top.
        byte_push(3'd0, 32'h1111_1111);
        byte_push(3'd7, 32'h2222_2222);
        byte_push(3'd3, 32'h00CC_BBAA);
        byte_push(3'd2, 32'h0000_9988);
        byte_push(3'd1, 32'h0000_00DD);
        byte_push(3'd1, 32'h0000_00EE);
        byte_push(3'd4, 32'h0000_0000);
        byte_push(3'd1, 32'h0000_00FF);

        // Random part: mostly programmed transfers fed to completion, with
        // noise, clear requests and the odd overflowing push mixed in.
        item_total = 0;
        while (item_total < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                if ($urandom_range(0, 7) == 0)
                    reg_wr(OFF_ADDR, 32'hFFFF_FFF0 | 32'($urandom_range(0, 15)));
                else
                    reg_wr(OFF_ADDR, $urandom);
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    xfer_len = $urandom_range(1, 16);
                else if (pick < 18)
                    xfer_len = $urandom_range(17, 64);
                else
                    xfer_len = 0;
                wd = $urandom;
                wd[DRX_SIZE_BITS-1:0] = DRX_SIZE_BITS'(xfer_len);
                if ($urandom_range(0, 1) == 0)
                    wd[31:DRX_SIZE_BITS] = '0;
                reg_wr(OFF_SIZE, wd);
                wd = $urandom;
                wd[CFG_CLR] = 1'b0;
                wd[CFG_EN]  = 1'b1;
                reg_wr(OFF_CFG, wd);
                // Sometimes a second descriptor queues behind the first, and
                // a further enable meets the full queue.
                if ($urandom_range(0, 3) == 0) begin
                    extra_len = $urandom_range(1, 12);
                    reg_wr(OFF_SIZE, 32'(extra_len));
                    reg_wr(OFF_CFG, wd);
                    reg_wr(OFF_CFG, wd);
                    xfer_len += extra_len;
                end
                if ($urandom_range(0, 3) == 0)
                    reg_rd(OFF_CFG);
                sent = 0;
                fill = 0;
                while (sent < xfer_len + 2) begin
                    if ($urandom_range(0, 9) == 0) begin
                        pick = $urandom_range(0, 2);
                        reg_rd(pick == 0 ? OFF_ADDR : (pick == 1 ? OFF_SIZE : OFF_CFG));
                    end
                    if ($urandom_range(0, 29) == 0)
                        byte_push(($urandom_range(0, 1) == 0) ? 3'd0
                                  : 3'($urandom_range(5, 7)), $urandom);
                    if ($urandom_range(0, 6) == 0)
                        nb = $urandom_range(1, 4);
                    else
                        nb = $urandom_range(1, 4 - fill);
                    byte_push(3'(nb), $urandom);
                    if (fill + nb <= 4) begin
                        sent += nb;
                        fill = (fill + nb) % 4;
                    end
                end
            end
            else if (pick <= 8) begin
                // Noise over every field. Size writes stay small so that a
                // stray enable cannot start a transfer that never ends.
                repeat (4) begin
                    k   = 2'($urandom_range(0, 3));
                    off = 4'($urandom);
                    wd  = $urandom;
                    if (off == OFF_SIZE)
                        wd[DRX_SIZE_BITS-1:6] = '0;
                    add_item(k, off, wd, 3'($urandom_range(0, 7)), $urandom);
                end
            end
            else begin
                wd = $urandom;
                wd[CFG_CLR] = 1'b1;
                reg_wr(OFF_CFG, wd);
                reg_rd(OFF_CFG);
            end
        end

        // Reset is held, then released once for good.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every item has been taken and every result has come.
        while (pending_items.size() != 0 || push || expected_results.size() != 0)
            @(posedge clk);
        // Any stray result after this point is caught by the monitor.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
